>>> rtl/core/gaf_pkg.sv
// ----------------------------------------------------------------------------
// gaf_pkg
// Shared types, pad bit positions and speed tables for the autofire mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package gaf_pkg;

	localparam int unsigned PadW   = 12;
	localparam int unsigned LinesW = 6;
	localparam int unsigned SpeedW = 3;
	localparam int unsigned CountW = 3;

	// pad button bit positions
	localparam int unsigned PadB      = 0;
	localparam int unsigned PadY      = 1;
	localparam int unsigned PadSelect = 2;
	localparam int unsigned PadStart  = 3;
	localparam int unsigned PadUp     = 4;
	localparam int unsigned PadDown   = 5;
	localparam int unsigned PadLeft   = 6;
	localparam int unsigned PadRight  = 7;
	localparam int unsigned PadA      = 8;
	localparam int unsigned PadX      = 9;
	localparam int unsigned PadL      = 10;
	localparam int unsigned PadR      = 11;

	// joystick line bit positions
	localparam int unsigned LineUp    = 5;
	localparam int unsigned LineDown  = 4;
	localparam int unsigned LineLeft  = 3;
	localparam int unsigned LineRight = 2;
	localparam int unsigned LineFire  = 1;
	localparam int unsigned LineFire2 = 0;

	localparam logic [SpeedW-1:0] SpeedReset = 3'd1;
	localparam logic [SpeedW-1:0] SpeedLast  = 3'd5;

	typedef struct packed {
		logic [PadW-1:0]   held_buttons;
		logic              poll_phase;
		logic              lock_on;
		logic              start_seen;
		logic              select_seen;
		logic [SpeedW-1:0] speed_index;
		logic [CountW-1:0] fire_count;
		logic              fire_phase;
	} gaf_state_t;

	typedef struct packed {
		logic [LinesW-1:0] joy_lines;
		logic              slow_base;
		logic              lock_active;
	} gaf_result_t;

	// ticks between fire phase flips; indices 0, 1 and the unreachable 6, 7 give 2
	function automatic logic [CountW-1:0] period_of(input logic [SpeedW-1:0] s);
		logic [CountW-1:0] p;
		unique case (s)
			3'd2, 3'd3: p = 3'd3;
			3'd4, 3'd5: p = 3'd4;
			default:    p = 3'd2;
		endcase
		return p;
	endfunction

	// 1 selects the 100 Hz tick base
	function automatic logic base_of(input logic [SpeedW-1:0] s);
		return (s == 3'd1) || (s == 3'd3) || (s == 3'd5);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/gaf_ifs.sv
// ----------------------------------------------------------------------------
// gaf_ifs
// Valid/ready channels: pad tick in, joystick result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gaf_pad_if;
	logic                     valid;
	logic                     ready;
	logic [gaf_pkg::PadW-1:0] pad_buttons;

	modport source (output valid, output pad_buttons, input ready);
	modport sink (input valid, input pad_buttons, output ready);
endinterface

interface gaf_joy_if;
	logic                       valid;
	logic                       ready;
	logic [gaf_pkg::LinesW-1:0] joy_lines;
	logic                       slow_base;
	logic                       lock_active;

	modport source (output valid, output joy_lines, output slow_base, output lock_active,
		input ready);
	modport sink (input valid, input joy_lines, input slow_base, input lock_active,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/gaf_step.sv
// ----------------------------------------------------------------------------
// gaf_step
// One tick of the mapper: latch, start edge, fire counter, line map, select.
// ----------------------------------------------------------------------------
`default_nettype none

module gaf_step (
	input  wire gaf_pkg::gaf_state_t           state,
	input  wire logic [gaf_pkg::PadW-1:0]      pad_buttons,
	output gaf_pkg::gaf_state_t                state_next,
	output gaf_pkg::gaf_result_t               result
);

	logic [gaf_pkg::PadW-1:0]   held;
	logic                       st;
	logic                       sel;
	logic                       lock;
	logic [gaf_pkg::CountW-1:0] cnt_load;
	logic                       phase;
	logic [gaf_pkg::SpeedW-1:0] speed;
	logic [gaf_pkg::LinesW-1:0] lines;

	always_comb begin
		// latch on every other tick
		held = state.poll_phase ? state.held_buttons : pad_buttons;

		st   = held[gaf_pkg::PadStart];
		lock = state.lock_on ^ (st & ~state.start_seen);

		if (state.fire_count == '0) begin
			cnt_load = gaf_pkg::period_of(state.speed_index);
			phase    = ~state.fire_phase;
		end else begin
			cnt_load = state.fire_count;
			phase    = state.fire_phase;
		end

		lines                     = '0;
		lines[gaf_pkg::LineUp]    = held[gaf_pkg::PadUp] | held[gaf_pkg::PadA];
		lines[gaf_pkg::LineDown]  = held[gaf_pkg::PadDown];
		lines[gaf_pkg::LineLeft]  = held[gaf_pkg::PadLeft];
		lines[gaf_pkg::LineRight] = held[gaf_pkg::PadRight];
		lines[gaf_pkg::LineFire]  = held[gaf_pkg::PadB]
			| (phase & (lock | held[gaf_pkg::PadY] | held[gaf_pkg::PadR]));
		lines[gaf_pkg::LineFire2] = held[gaf_pkg::PadX] | held[gaf_pkg::PadL];

		// advance speed on select edge, wrap past the last index
		sel = held[gaf_pkg::PadSelect];
		if (sel & ~state.select_seen) begin
			speed = (state.speed_index >= gaf_pkg::SpeedLast) ? '0
				: state.speed_index + 3'd1;
		end else begin
			speed = state.speed_index;
		end

		state_next.held_buttons = held;
		state_next.poll_phase   = ~state.poll_phase;
		state_next.lock_on      = lock;
		state_next.start_seen   = st;
		state_next.select_seen  = sel;
		state_next.speed_index  = speed;
		state_next.fire_count   = cnt_load - 3'd1;
		state_next.fire_phase   = phase;

		result.joy_lines   = lines;
		result.slow_base   = gaf_pkg::base_of(speed);
		result.lock_active = lock;
	end

endmodule

`default_nettype wire

>>> rtl/core/gamepad_autofire_mapper.sv
// ----------------------------------------------------------------------------
// gamepad_autofire_mapper
// Maps latched pad buttons to six joystick lines with selectable autofire.
// Path: a tick goes into the input register, then its result into the result
//   register, which holds it back while full and joy.ready is low.
// Throughput: one tick per cycle unless joy stalls; single-pass step logic updates state.
// Reset: arst_n clears valid flags and mapper state, speed index returns to 1; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_autofire_mapper (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gaf_pad_if.sink    pad,
	gaf_joy_if.source  joy
);

	logic                     valid_s1;
	logic [gaf_pkg::PadW-1:0] pad_s1;
	logic                     valid_s2;
	gaf_pkg::gaf_result_t     result_s2;
	gaf_pkg::gaf_state_t      state_q;
	gaf_pkg::gaf_state_t      state_next;
	gaf_pkg::gaf_result_t     result;
	logic                     advance;

	// move s1 on when the result register is free or being drained
	assign advance   = valid_s1 & (~valid_s2 | joy.ready);
	assign pad.ready = ~valid_s1 | advance;

	gaf_step u_step (
		.state       (state_q),
		.pad_buttons (pad_s1),
		.state_next  (state_next),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{held_buttons: '0, poll_phase: 1'b0, lock_on: 1'b0,
				start_seen: 1'b0, select_seen: 1'b0, speed_index: gaf_pkg::SpeedReset,
				fire_count: '0, fire_phase: 1'b0};
		end else begin
			if (pad.ready) begin
				valid_s1 <= pad.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (joy.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pad.valid && pad.ready) begin
			pad_s1 <= pad.pad_buttons;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign joy.valid       = valid_s2;
	assign joy.joy_lines   = result_s2.joy_lines;
	assign joy.slow_base   = result_s2.slow_base;
	assign joy.lock_active = result_s2.lock_active;

endmodule

`default_nettype wire

>>> dv/gamepad_autofire_mapper_tb.sv
// ----------------------------------------------------------------------------
// gamepad_autofire_mapper_tb
// Drives pad ticks through the valid/ready input channel and checks every
// joystick result against a cycle-free model of latching, lock-on, fire phase
// and speed selection, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_autofire_mapper_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [gaf_pkg::PadW-1:0] pad_t;

	// Tracks the mapper's state and holds the joystick results still owed.
	class autofire_tracker;
		logic [gaf_pkg::PadW-1:0]   held;
		logic                       poll_odd;
		logic                       lock;
		logic                       start_prev;
		logic                       select_prev;
		logic [gaf_pkg::SpeedW-1:0] speed;
		logic [gaf_pkg::CountW-1:0] count;
		logic                       phase;
		gaf_pkg::gaf_result_t       owed_joy[$];
		int                         fails;
		int                         joy_seen;

		function new();
			held        = '0;
			poll_odd    = 1'b0;
			lock        = 1'b0;
			start_prev  = 1'b0;
			select_prev = 1'b0;
			speed       = gaf_pkg::SpeedReset;
			count       = '0;
			phase       = 1'b0;
			fails       = 0;
			joy_seen    = 0;
		endfunction

		function void take_tick(input logic [gaf_pkg::PadW-1:0] pad_v);
			gaf_pkg::gaf_result_t r;
			logic [gaf_pkg::LinesW-1:0] lines;
			if (!poll_odd)
				held = pad_v;
			poll_odd = ~poll_odd;

			if (held[gaf_pkg::PadStart] && !start_prev)
				lock = ~lock;
			start_prev = held[gaf_pkg::PadStart];

			if (count == '0) begin
				if (speed > gaf_pkg::SpeedLast || speed < 3'd2)
					count = 3'd2;
				else if (speed < 3'd4)
					count = 3'd3;
				else
					count = 3'd4;
				phase = ~phase;
			end
			count = count - 3'd1;

			lines = '0;
			lines[gaf_pkg::LineUp]    = held[gaf_pkg::PadUp] | held[gaf_pkg::PadA];
			lines[gaf_pkg::LineDown]  = held[gaf_pkg::PadDown];
			lines[gaf_pkg::LineLeft]  = held[gaf_pkg::PadLeft];
			lines[gaf_pkg::LineRight] = held[gaf_pkg::PadRight];
			lines[gaf_pkg::LineFire]  = held[gaf_pkg::PadB]
				| (phase & (lock | held[gaf_pkg::PadY] | held[gaf_pkg::PadR]));
			lines[gaf_pkg::LineFire2] = held[gaf_pkg::PadX] | held[gaf_pkg::PadL];

			if (held[gaf_pkg::PadSelect] && !select_prev)
				speed = (speed >= gaf_pkg::SpeedLast) ? '0 : speed + 3'd1;
			select_prev = held[gaf_pkg::PadSelect];

			r.joy_lines   = lines;
			r.slow_base   = speed[0] && (speed <= gaf_pkg::SpeedLast);
			r.lock_active = lock;
			owed_joy.push_back(r);
		endfunction

		function void match_joy(input logic [gaf_pkg::LinesW-1:0] lines, input logic base,
			input logic lock_v);
			gaf_pkg::gaf_result_t e;
			joy_seen++;
			if (owed_joy.size() == 0) begin
				$error("unexpected result: joy_lines %0h slow_base %0b lock_active %0b",
					lines, base, lock_v);
				fails++;
				return;
			end
			e = owed_joy.pop_front();
			if (lines !== e.joy_lines) begin
				$error("joy_lines: expected %0h, actual %0h", e.joy_lines, lines);
				fails++;
			end
			if (base !== e.slow_base) begin
				$error("slow_base: expected %0b, actual %0b", e.slow_base, base);
				fails++;
			end
			if (lock_v !== e.lock_active) begin
				$error("lock_active: expected %0b, actual %0b", e.lock_active, lock_v);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gaf_pad_if pad_ch ();
	gaf_joy_if joy_ch ();

	gamepad_autofire_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pad    (pad_ch),
		.joy    (joy_ch)
	);

	autofire_tracker tracker = new();
	bit              no_gap;
	bit              held_off;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_tick(input logic [gaf_pkg::PadW-1:0] v);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			pad_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pad_ch.valid       <= 1'b1;
		pad_ch.pad_buttons <= v;
		do @(posedge clk); while (!pad_ch.ready);
	endtask

	// latch tick carries v, the ignored tick after it carries noise
	task automatic send_latched(input logic [gaf_pkg::PadW-1:0] v);
		send_tick(v);
		send_tick(pad_t'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pad_ch.valid && pad_ch.ready)
				tracker.take_tick(pad_ch.pad_buttons);
			if (joy_ch.valid && joy_ch.ready)
				tracker.match_joy(joy_ch.joy_lines, joy_ch.slow_base, joy_ch.lock_active);
		end
	end

	// result side: random stalls, plus one long hold-off to back the block up
	initial begin
		int gap;
		joy_ch.ready <= 1'b0;
		held_off = 1'b0;
		repeat (3) @(posedge clk);
		forever begin
			if (!held_off && tracker.joy_seen >= 600) begin
				held_off = 1'b1;
				joy_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				joy_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			joy_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? 100 : $urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int hold;
		logic [gaf_pkg::PadW-1:0] v;
		pad_ch.valid       <= 1'b0;
		pad_ch.pad_buttons <= '0;
		arst_n             <= 1'b0;
		no_gap = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: nothing, everything, then each button alone
		send_latched('0);
		send_latched('1);
		for (int b = 0; b < gaf_pkg::PadW; b++)
			send_latched(pad_t'(1) << b);

		// random: pad states held for an even number of ticks, some noise
		sent = 0;
		no_gap = 1'b1;
		while (sent < 1800) begin
			if (sent >= 150)
				no_gap = 1'b0;
			if ($urandom_range(0, 99) < 15) begin
				hold = $urandom_range(1, 5);
				repeat (hold) send_tick(pad_t'($urandom));
			end else begin
				v = pad_t'($urandom);
				v[gaf_pkg::PadStart]  = ($urandom_range(0, 3) == 0);
				v[gaf_pkg::PadSelect] = ($urandom_range(0, 3) == 0);
				hold = 2 * $urandom_range(1, 4);
				repeat (hold) send_tick(v);
			end
			sent += hold;
		end
		pad_ch.valid <= 1'b0;

		while (tracker.owed_joy.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
